FILE: design/wbl_pkg.sv
package wbl_pkg;

  localparam int SIZE_W         = 20;
  localparam int LIMIT_W        = 32;
  localparam int PERIOD_W       = 16;
  localparam int RATE_W         = 32;
  localparam int CFG_INDEX_W    = 8;
  localparam int CFG_DATA_W     = 32;
  localparam int WINDOW_DEFAULT = 16;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET        = '0;
  localparam logic [PERIOD_W-1:0] TREND_PERIOD_RESET = PERIOD_W'(50);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LIMIT_BYTES  = CFG_INDEX_W'(0),
    CFG_TREND_PERIOD = CFG_INDEX_W'(1)
  } cfg_reg_t;

  typedef enum logic {
    REQ_MESSAGE = 1'b0,
    REQ_TICK    = 1'b1
  } req_kind_t;

  // control word handed from the budget stage to the ring stage
  typedef struct packed {
    logic valid;
    logic drop;
    logic close;
  } wbl_stage_t;

  function automatic int rem_width(input int window);
    return $clog2(window);
  endfunction

  function automatic int scaled_width(input int window);
    return SIZE_W + $clog2(window + 1);
  endfunction

  // type, size, size / window, size % window, size * window
  function automatic int item_width(input int window);
    return 1 + 2 * SIZE_W + rem_width(window) + scaled_width(window);
  endfunction

endpackage

FILE: design/windowed_bandwidth_limiter_unit.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid / req_stall req_type, msg_len
// rsp       out        rsp_valid / rsp_stall drop, avg_rate
// cfg       in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request per cycle sustained while rsp_stall is low; the result passes through
// two divide stages, the queue, the budget stage and the ring stage.
// The budget stage's period-count update is the feedback loop that sets the rate.
// rst is synchronous: clears the pipeline, queue, period state and ring valid bits.
// rsp_stall holds the output; the 4-entry queue absorbs it before req_stall rises.
module windowed_bandwidth_limiter_unit
  import wbl_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic                   req_type,
  input  logic [SIZE_W-1:0]      msg_len,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic                   drop,
  output logic [RATE_W-1:0]      avg_rate,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ITEM_W = item_width(WINDOW);
  localparam int REM_W  = rem_width(WINDOW);

  logic [LIMIT_W-1:0]  limit_bytes;
  logic [PERIOD_W-1:0] trend_period_ticks;

  logic                push;
  logic [ITEM_W-1:0]   push_data;
  logic                full;
  logic                pop;
  logic [ITEM_W-1:0]   pop_data;
  logic                empty;
  logic                take;
  wbl_stage_t          stage;
  logic [RATE_W-1:0]   close_quot;
  logic [REM_W-1:0]    close_rem;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_bytes        <= LIMIT_RESET;
      trend_period_ticks <= TREND_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LIMIT_BYTES:  limit_bytes        <= cfg_data[LIMIT_W-1:0];
        CFG_TREND_PERIOD: trend_period_ticks <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  wbl_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .msg_len   (msg_len),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  wbl_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  wbl_exec #(
    .WINDOW (WINDOW)
  ) u_exec (
    .clk                (clk),
    .rst                (rst),
    .limit_bytes        (limit_bytes),
    .trend_period_ticks (trend_period_ticks),
    .empty              (empty),
    .pop_data           (pop_data),
    .pop                (pop),
    .take               (take),
    .stage              (stage),
    .close_quot         (close_quot),
    .close_rem          (close_rem)
  );

  wbl_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .close_quot (close_quot),
    .close_rem  (close_rem),
    .take       (take),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .drop       (drop),
    .avg_rate   (avg_rate)
  );

endmodule

FILE: design/wbl_front.sv
module wbl_front
  import wbl_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          req_type,
  input  logic [SIZE_W-1:0]             msg_len,
  output logic                          push,
  output logic [item_width(WINDOW)-1:0] push_data,
  input  logic                          full
);

  localparam int REM_W     = rem_width(WINDOW);
  localparam int SCALED_W  = scaled_width(WINDOW);
  localparam int DIV_SHIFT = SIZE_W + $clog2(WINDOW);
  localparam int PROD_W    = SIZE_W + DIV_SHIFT;
  // ceil(2^k / WINDOW): exact floor quotient for every SIZE_W-bit size
  localparam logic [DIV_SHIFT-1:0] DIV_MULT =
    DIV_SHIFT'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic                valid_a;
  logic                type_a;
  logic [SIZE_W-1:0]   size_a;
  logic [SIZE_W-1:0]   quot_a;
  logic                valid_b;
  logic                type_b;
  logic [SIZE_W-1:0]   size_b;
  logic [SIZE_W-1:0]   quot_b;
  logic [REM_W-1:0]    rem_b;
  logic [SCALED_W-1:0] scaled_b;

  logic                en_a;
  logic                en_b;
  logic [PROD_W-1:0]   prod;
  logic [SIZE_W-1:0]   quot_times_w;
  logic [SIZE_W-1:0]   rem_full;
  logic [SCALED_W-1:0] scaled_a;

  assign en_b      = !valid_b || !full;
  assign en_a      = !valid_a || en_b;
  assign req_stall = !en_a;
  assign push      = valid_b && !full;
  assign push_data = {type_b, size_b, quot_b, rem_b, scaled_b};

  assign prod         = PROD_W'(msg_len) * PROD_W'(DIV_MULT);
  assign quot_times_w = SIZE_W'(quot_a * SIZE_W'(WINDOW));
  assign rem_full     = size_a - quot_times_w;
  assign scaled_a     = SCALED_W'(size_a) * SCALED_W'(WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else begin
      if (en_a) begin
        valid_a <= req_valid;
      end
      if (en_b) begin
        valid_b <= valid_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && req_valid) begin
      type_a <= req_type;
      size_a <= msg_len;
      quot_a <= prod[DIV_SHIFT +: SIZE_W];
    end
    if (en_b && valid_a) begin
      type_b   <= type_a;
      size_b   <= size_a;
      quot_b   <= quot_a;
      rem_b    <= rem_full[REM_W-1:0];
      scaled_b <= scaled_a;
    end
  end

endmodule

FILE: design/wbl_fifo.sv
module wbl_fifo
  import wbl_pkg::*;
#(
  parameter int WIDTH = item_width(WINDOW_DEFAULT),
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == (AW + 1)'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (AW + 1)'(1);
        2'b01:   count <= count - (AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: design/wbl_exec.sv
module wbl_exec
  import wbl_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [LIMIT_W-1:0]            limit_bytes,
  input  logic [PERIOD_W-1:0]           trend_period_ticks,
  input  logic                          empty,
  input  logic [item_width(WINDOW)-1:0] pop_data,
  output logic                          pop,
  input  logic                          take,
  output wbl_stage_t                    stage,
  output logic [RATE_W-1:0]             close_quot,
  output logic [rem_width(WINDOW)-1:0]  close_rem
);

  localparam int REM_W    = rem_width(WINDOW);
  localparam int SCALED_W = scaled_width(WINDOW);

  logic                item_type;
  logic [SIZE_W-1:0]   item_size;
  logic [SIZE_W-1:0]   item_quot;
  logic [REM_W-1:0]    item_rem;
  logic [SCALED_W-1:0] item_scaled;

  logic [LIMIT_W-1:0]  period_bytes;
  logic [RATE_W-1:0]   period_quot;
  logic [REM_W-1:0]    period_rem;
  logic [PERIOD_W-1:0] elapsed;

  logic [LIMIT_W-1:0]  period_bytes_next;
  logic [RATE_W-1:0]   period_quot_next;
  logic [REM_W-1:0]    period_rem_next;
  logic [PERIOD_W-1:0] elapsed_next;
  logic [RATE_W-1:0]   kept_quot;
  logic [REM_W-1:0]    kept_rem;
  logic                drop_next;
  logic                close_next;

  logic [LIMIT_W:0]    total;
  logic                over_share;
  logic [REM_W:0]      rem_sum;
  logic                rem_carry;
  logic [RATE_W-1:0]   admit_quot;
  logic [REM_W-1:0]    admit_rem;
  logic                en_e;

  assign {item_type, item_size, item_quot, item_rem, item_scaled} = pop_data;

  assign en_e = !stage.valid || take;
  assign pop  = !empty && en_e;

  // size > floor(limit / WINDOW) is the same test as size * WINDOW > limit
  assign total      = {1'b0, period_bytes} + (LIMIT_W + 1)'(item_size);
  assign over_share = LIMIT_W'(item_scaled) > limit_bytes;
  assign rem_sum    = (REM_W + 1)'(period_rem) + (REM_W + 1)'(item_rem);
  assign rem_carry  = rem_sum >= (REM_W + 1)'(WINDOW);
  assign admit_quot = period_quot + RATE_W'(item_quot) + RATE_W'(rem_carry);
  assign admit_rem  = rem_carry ? REM_W'(rem_sum - (REM_W + 1)'(WINDOW)) : REM_W'(rem_sum);

  always_comb begin
    period_bytes_next = period_bytes;
    period_quot_next  = period_quot;
    period_rem_next   = period_rem;
    elapsed_next      = elapsed;
    kept_quot         = period_quot;
    kept_rem          = period_rem;
    drop_next         = 1'b0;
    close_next        = 1'b0;
    if (item_type == REQ_TICK) begin
      if (elapsed != '1) begin
        elapsed_next = elapsed + PERIOD_W'(1);
      end
    end else if (limit_bytes != '0) begin
      if (over_share || total > {1'b0, limit_bytes}) begin
        drop_next = 1'b1;
      end else begin
        period_bytes_next = total[LIMIT_W-1:0];
        period_quot_next  = admit_quot;
        period_rem_next   = admit_rem;
        kept_quot         = admit_quot;
        kept_rem          = admit_rem;
      end
      // period ends after the admission decision
      if (elapsed > trend_period_ticks) begin
        close_next        = 1'b1;
        period_bytes_next = '0;
        period_quot_next  = '0;
        period_rem_next   = '0;
        elapsed_next      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid  <= 1'b0;
      period_bytes <= '0;
      period_quot  <= '0;
      period_rem   <= '0;
      elapsed      <= '0;
    end else begin
      if (en_e) begin
        stage.valid <= !empty;
      end
      if (pop) begin
        stage.drop   <= drop_next;
        stage.close  <= close_next;
        period_bytes <= period_bytes_next;
        period_quot  <= period_quot_next;
        period_rem   <= period_rem_next;
        elapsed      <= elapsed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      close_quot <= kept_quot;
      close_rem  <= kept_rem;
    end
  end

endmodule

FILE: design/wbl_ring.sv
module wbl_ring
  import wbl_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wbl_stage_t                   stage,
  input  logic [RATE_W-1:0]            close_quot,
  input  logic [rem_width(WINDOW)-1:0] close_rem,
  output logic                         take,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic                         drop,
  output logic [RATE_W-1:0]            avg_rate
);

  localparam int REM_W   = rem_width(WINDOW);
  localparam int PTR_W   = $clog2(WINDOW);
  localparam int ENTRY_W = RATE_W + REM_W;

  // each slot keeps a period count as quotient and remainder by WINDOW,
  // so the mean is the running quotient sum with a remainder carry
  logic [ENTRY_W-1:0] ring_mem [WINDOW];
  logic [WINDOW-1:0]  ring_valid;
  logic [ENTRY_W-1:0] old_entry;
  logic [PTR_W-1:0]   ptr;
  logic [PTR_W-1:0]   ptr_next;
  logic [RATE_W-1:0]  mean_rate;
  logic [REM_W-1:0]   rate_rem;

  logic               advance;
  logic               do_close;
  logic [RATE_W-1:0]  old_quot;
  logic [REM_W-1:0]   old_rem;
  logic [REM_W+1:0]   rem_tmp;
  logic               rem_neg;
  logic               rem_big;
  logic [REM_W+1:0]   rem_fix;
  logic [RATE_W+1:0]  mean_tmp;
  logic [RATE_W-1:0]  mean_next;

  assign take     = !rsp_valid || !rsp_stall;
  assign advance  = stage.valid && take;
  assign do_close = advance && stage.close;
  assign ptr_next = !do_close ? ptr :
                    (ptr == PTR_W'(WINDOW - 1)) ? '0 : ptr + PTR_W'(1);

  assign {old_quot, old_rem} = old_entry;

  assign rem_tmp = (REM_W + 2)'(rate_rem) + (REM_W + 2)'(close_rem) - (REM_W + 2)'(old_rem);
  assign rem_neg = rem_tmp[REM_W+1];
  assign rem_big = !rem_neg && (rem_tmp >= (REM_W + 2)'(WINDOW));
  assign rem_fix = rem_neg ? rem_tmp + (REM_W + 2)'(WINDOW) :
                   rem_big ? rem_tmp - (REM_W + 2)'(WINDOW) : rem_tmp;

  assign mean_tmp  = (RATE_W + 2)'(mean_rate) + (RATE_W + 2)'(close_quot)
                   - (RATE_W + 2)'(old_quot) + (RATE_W + 2)'(rem_big)
                   - (RATE_W + 2)'(rem_neg);
  assign mean_next = do_close ? mean_tmp[RATE_W-1:0] : mean_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid <= '0;
      ptr        <= '0;
      mean_rate  <= '0;
      rate_rem   <= '0;
      rsp_valid  <= 1'b0;
      old_entry  <= '0;
    end else begin
      if (do_close) begin
        ring_valid[ptr] <= 1'b1;
        rate_rem        <= rem_fix[REM_W-1:0];
      end
      ptr       <= ptr_next;
      mean_rate <= mean_next;
      // prefetch the slot that the next close overwrites
      old_entry <= ring_valid[ptr_next] ? ring_mem[ptr_next] : '0;
      if (take) begin
        rsp_valid <= stage.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_close) begin
      ring_mem[ptr] <= {close_quot, close_rem};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drop     <= stage.drop;
      avg_rate <= mean_next;
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    32'(rate_rem) < WINDOW)
    else $error("ring remainder out of range");

  a_close_fills_slot: assert property (@(posedge clk) disable iff (rst)
    do_close |=> ring_valid[$past(ptr)])
    else $error("closed period not stored in ring");

  a_mean_on_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> (avg_rate == mean_rate))
    else $error("reported rate differs from running mean");

  a_ptr_moves_on_close: assert property (@(posedge clk) disable iff (rst)
    !do_close |=> $stable(ptr))
    else $error("ring pointer moved without a close");

endmodule

FILE: verif/windowed_bandwidth_limiter_unit_test.sv
module windowed_bandwidth_limiter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wbl_pkg::*;

  localparam int WINDOW      = WINDOW_DEFAULT;
  localparam int CYCLE_LIMIT = 1_000_000;
  // decodes to no register; the write must be ignored
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG = CFG_INDEX_W'(8'hA5);
  localparam logic [PERIOD_W-1:0] TICKS_SATURATED = '1;
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  typedef struct packed {
    logic              drop;
    logic [RATE_W-1:0] rate;
  } admission_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  logic                   req_type = REQ_MESSAGE;
  logic [SIZE_W-1:0]      msg_len = '0;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  logic                   drop;
  logic [RATE_W-1:0]      avg_rate;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  windowed_bandwidth_limiter_unit #(.WINDOW(WINDOW)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .msg_len   (msg_len),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .drop      (drop),
    .avg_rate  (avg_rate),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // limiter state as the block should hold it
  logic [LIMIT_W-1:0]  budget_limit;
  logic [PERIOD_W-1:0] trend_period;
  logic [LIMIT_W-1:0]  period_bytes;
  logic [RATE_W-1:0]   rate_history [WINDOW];
  int unsigned         history_slot;
  logic [63:0]         history_sum;
  logic [RATE_W-1:0]   mean_rate;
  logic [PERIOD_W-1:0] elapsed_ticks;

  admission_t admission_q[$];

  int mismatches;
  int send_idle_pct;
  int rsp_idle_pct;
  int message_count;
  int tick_count;
  int drop_count;
  int period_count;
  int write_count;
  int cycle_count;

  function automatic void clear_limiter_state();
    budget_limit  = LIMIT_RESET;
    trend_period  = TREND_PERIOD_RESET;
    period_bytes  = '0;
    history_slot  = 0;
    history_sum   = '0;
    mean_rate     = '0;
    elapsed_ticks = '0;
    for (int i = 0; i < WINDOW; i++) rate_history[i] = '0;
  endfunction

  function automatic void close_trend_period();
    history_sum = history_sum - 64'(rate_history[history_slot]) + 64'(period_bytes);
    rate_history[history_slot] = period_bytes;
    history_slot = (history_slot == WINDOW - 1) ? 0 : history_slot + 1;
    mean_rate = RATE_W'(history_sum / WINDOW);
    period_bytes = '0;
    elapsed_ticks = '0;
    period_count++;
  endfunction

  function automatic admission_t admit_request(req_kind_t kind, logic [SIZE_W-1:0] size);
    logic [LIMIT_W-1:0] per_message;
    logic [LIMIT_W:0]   total;
    admission_t         res;
    res.drop = 1'b0;
    if (kind == REQ_TICK) begin
      tick_count++;
      if (elapsed_ticks != TICKS_SATURATED) elapsed_ticks++;
    end else begin
      message_count++;
      if (budget_limit != '0) begin
        per_message = budget_limit / WINDOW;
        total = {1'b0, period_bytes} + (LIMIT_W + 1)'(size);
        if (LIMIT_W'(size) > per_message || total > {1'b0, budget_limit}) begin
          res.drop = 1'b1;
        end else begin
          period_bytes = total[LIMIT_W-1:0];
        end
        // the period check runs whether or not the message was dropped
        if (elapsed_ticks > trend_period) close_trend_period();
      end
    end
    if (res.drop) drop_count++;
    res.rate = mean_rate;
    return res;
  endfunction

  task automatic send_request(req_kind_t kind, logic [SIZE_W-1:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= kind;
    msg_len   <= size;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    admission_q.insert(admission_q.size(), admit_request(kind, size));
  endtask

  task automatic send_message(logic [SIZE_W-1:0] size);
    send_request(REQ_MESSAGE, size);
  endtask

  task automatic send_ticks(int count);
    for (int i = 0; i < count; i++) send_request(REQ_TICK, SIZE_W'($urandom));
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (admission_q.size() != 0) @(posedge clk);
  endtask

  // every request yields exactly one result, so an empty queue means idle
  task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    write_count++;
    case (index)
      CFG_LIMIT_BYTES:  budget_limit = data[LIMIT_W-1:0];
      CFG_TREND_PERIOD: trend_period = data[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    logic [LIMIT_W-1:0] per_message;
    int unsigned        cap;
    per_message = budget_limit / WINDOW;
    cap = per_message + per_message / 4 + 1;
    if (cap > SIZE_MAX) cap = SIZE_MAX;
    case ($urandom_range(9))
      0, 1:    return SIZE_W'($urandom);
      2:       return $urandom_range(1) ? SIZE_MAX : '0;
      default: return SIZE_W'($urandom_range(cap, 0));
    endcase
  endfunction

  always @(posedge clk) begin : check_results
    admission_t want;
    rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
    if (!rst && rsp_valid && !rsp_stall) begin
      if (admission_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result drop %0b rate %0d", $time, drop, avg_rate);
      end else begin
        want = admission_q.pop_front();
        if (drop !== want.drop) begin
          mismatches++;
          $display("%0t ns: drop expected %0b actual %0b", $time, want.drop, drop);
        end
        if (avg_rate !== want.rate) begin
          mismatches++;
          $display("%0t ns: avg_rate expected %0d actual %0d",
                   $time, want.rate, avg_rate);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, admission_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // out of reset the limit is zero: everything passes and nothing moves
  task automatic test_limit_zero();
    send_message('0);
    send_message(SIZE_MAX);
    send_ticks(2);
    send_message(SIZE_W'(12345));
  endtask

  // limit 160 gives 10 bytes per message; sixteen of them fill the period
  task automatic test_budget();
    write_register(CFG_LIMIT_BYTES, 32'd160);
    write_register(CFG_TREND_PERIOD, 32'd2);
    send_message(SIZE_W'(10));
    send_message(SIZE_W'(11));
    send_message('0);
    for (int i = 0; i < 15; i++) send_message(SIZE_W'(10));
    send_message(SIZE_W'(1));
  endtask

  // a dropped message still closes an expired period
  task automatic test_period_close();
    send_ticks(3);
    send_message(SIZE_W'(11));
    send_ticks(1);
    send_message(SIZE_W'(4));
  endtask

  task automatic test_limit_lowered();
    for (int i = 0; i < 9; i++) send_message(SIZE_W'(10));
    write_register(CFG_LIMIT_BYTES, 32'd48);
    send_message(SIZE_W'(1));
    send_message(SIZE_W'(3));
    send_ticks(3);
    send_message(SIZE_W'(2));
    send_message(SIZE_W'(2));
  endtask

  // only the low half of the data reaches the period register
  task automatic test_zero_period();
    write_register(CFG_TREND_PERIOD, 32'hABCD_0000);
    send_message(SIZE_W'(2));
    send_ticks(1);
    send_message(SIZE_W'(2));
    send_message(SIZE_W'(3));
  endtask

  task automatic test_unused_index();
    write_register(CFG_NO_REG, '1);
    send_message(SIZE_W'(3));
    send_message(SIZE_W'(4));
    send_ticks(1);
    send_message(SIZE_W'(1));
  endtask

  // with the longest period a run of ticks does not end it
  task automatic test_long_period();
    write_register(CFG_TREND_PERIOD, 32'(TICKS_SATURATED));
    send_ticks(40);
    send_message(SIZE_W'(1));
    write_register(CFG_TREND_PERIOD, 32'(TICKS_SATURATED - 1));
    send_message(SIZE_W'(1));
  endtask

  // full-scale limit: every size fits the share and the period count keeps growing
  task automatic test_full_width_budget();
    write_register(CFG_LIMIT_BYTES, '1);
    write_register(CFG_TREND_PERIOD, 32'(TICKS_SATURATED));
    for (int i = 0; i < 20; i++) send_message(SIZE_MAX);
    send_message(SIZE_MAX);
    send_message(SIZE_W'(4095));
    send_message(SIZE_W'(1));
  endtask

  task automatic test_random_traffic();
    logic [LIMIT_W-1:0]  limit_value;
    logic [PERIOD_W-1:0] period_value;
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 63 : 0;
      rsp_idle_pct  = (mode == 0) ? 63 : (mode == 1) ? 17 : 0;
      for (int phase = 0; phase < 4; phase++) begin
        case ($urandom_range(5))
          0:       limit_value = '0;
          1:       limit_value = '1;
          2:       limit_value = $urandom;
          default: limit_value = $urandom_range(1 << 24, 16);
        endcase
        case ($urandom_range(5))
          0:       period_value = '0;
          1:       period_value = TICKS_SATURATED;
          default: period_value = PERIOD_W'($urandom_range(6, 1));
        endcase
        write_register(CFG_LIMIT_BYTES, limit_value);
        write_register(CFG_TREND_PERIOD, 32'(period_value));
        for (int i = 0; i < 124; i++) begin
          if (i == 62) wait_for_results();
          if ($urandom_range(99) < 30) send_ticks(1);
          else send_message(pick_size());
        end
      end
    end
  endtask

  initial begin
    clear_limiter_state();
    send_idle_pct = 17;
    rsp_idle_pct  = 63;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_limit_zero();
    test_budget();
    test_period_close();
    test_limit_lowered();
    test_zero_period();
    test_unused_index();
    test_long_period();
    test_full_width_budget();
    test_random_traffic();

    wait_for_results();
    repeat (10) @(posedge clk);
    if (admission_q.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", admission_q.size());
    end
    $display("Ran %0d messages (%0d dropped) and %0d ticks, %0d trend periods closed,",
             message_count, drop_count, tick_count, period_count);
    $display("%0d register writes, limits from zero to full scale, with and without stalls.",
             write_count);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
